// File: rtl/core/qamsw_pkg.sv
// qamsw_pkg: shared widths, constants and control structs for the QAM sweep unit.
// No dependencies; imported by the controller, datapath and top level.
package qamsw_pkg;

    localparam int NUM_MODS       = 6;
    localparam int DAC_FULL_SCALE = 4095;
    localparam int TIME_BITS      = 32;

    localparam int MOD_W   = 3;                                  // modulation select
    localparam int IDX_W   = 6;                                  // max bits per axis
    localparam int CNT_W   = 2 * IDX_W;                          // symbol counter
    localparam int CODE_W  = 12;                                 // DAC code
    localparam int CFG_W   = 16;                                 // config data
    localparam int CIDX_W  = 2;                                  // config index
    localparam int PROD_W  = IDX_W + $clog2(DAC_FULL_SCALE + 1); // index * full scale
    localparam int STEP_W  = $clog2(PROD_W);

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(50);
    localparam logic [CFG_W-1:0] LONG_RST     = CFG_W'(1500);

    localparam logic [CIDX_W-1:0] REG_DEBOUNCE = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_LONG     = CIDX_W'(1);

    localparam logic OP_POLL   = 1'b0;
    localparam logic OP_SYMBOL = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic take_in;   // latch input item, set up symbol division
        logic div_step;  // one restoring-divide step on both lanes
        logic poll_deb;  // debounce / press / release evaluation
        logic poll_long; // long-press evaluation
        logic load_out;  // load output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_op;     // op of the item on the input port
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage

// File: rtl/core/qam_sweep_with_button_control_unit.sv
// qam_sweep_with_button_control_unit: top level of the QAM constellation sweep unit.
// Depends on qamsw_pkg, qamsw_ctrl and qamsw_dp.
//
// Steps through a square QAM constellation (QPSK up to 4096-QAM, selected by
// o_mod_select + 1 bits per axis) and drives 12-bit I/Q DAC codes, one symbol
// per symbol-clock item; button polls carry a millisecond time, are debounced,
// and a short press advances the modulation in transmit mode while a long
// press toggles transmit/receive. Every accepted item gives exactly one result
// transfer. A symbol item runs from transfer in to result load as a set-up,
// 18 restoring-divide steps and a load: the two axis codes,
// index*4095/(2^b-1), are formed by a pair of shared dividers that retire one
// quotient bit per cycle. A button poll runs through set-up, debounce and
// press evaluation, long-press evaluation and load. One item is worked at a time;
// o_in_stall is high while an item is in progress, and a
// finished result sits in the output register so the next item can be taken
// while the sink stalls. Configuration writes (index 0 debounce time, index 1
// long-press hold time, others ignored) are always ready and must only be issued
// while the unit is idle. Reset is synchronous, active low.
module qam_sweep_with_button_control_unit
    import qamsw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic               i_button_level,
    input  logic [31:0]        i_now_ms,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_dac_valid,
    output logic [CODE_W-1:0]  o_i_code,
    output logic [CODE_W-1:0]  o_q_code,
    output logic               o_short_press,
    output logic               o_mode_toggled,
    output logic               o_rx_mode,
    output logic [MOD_W-1:0]   o_mod_select,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // the user must let registers change only while idle; the block does not enforce it
    assign o_cfg_ready = 1'b1;

    qamsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    qamsw_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_button_level (i_button_level),
        .i_now_ms       (i_now_ms),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_dac_valid    (o_dac_valid),
        .o_i_code       (o_i_code),
        .o_q_code       (o_q_code),
        .o_short_press  (o_short_press),
        .o_mode_toggled (o_mode_toggled),
        .o_rx_mode      (o_rx_mode),
        .o_mod_select   (o_mod_select)
    );

endmodule

// File: rtl/core/qamsw_ctrl.sv
// qamsw_ctrl: sequencer for the QAM sweep unit (accept, divide, poll, output).
// Depends on qamsw_pkg.
module qamsw_ctrl
    import qamsw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DEB,
        S_LONG,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.take_in   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.poll_deb  = (r_state == S_DEB);
        o_cmd.poll_long = (r_state == S_LONG);
        o_cmd.load_out  = (r_state == S_DONE) && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (i_in_valid) begin
                        r_state <= (i_stat.in_op == OP_SYMBOL) ? S_DIV : S_DEB;
                    end
                end
                S_DIV: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(PROD_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DEB:  r_state <= S_LONG;
                S_LONG: r_state <= S_DONE;
                S_DONE: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/qamsw_dp.sv
// qamsw_dp: QAM sweep datapath: config, sweep and button state, two divide lanes,
// output register. Depends on qamsw_pkg; driven by qamsw_ctrl.
module qamsw_dp
    import qamsw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    // config
    input  logic               i_cfg_valid,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // input fields
    input  logic               i_op,
    input  logic               i_button_level,
    input  logic [31:0]        i_now_ms,
    // output channel
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic               o_dac_valid,
    output logic [CODE_W-1:0]  o_i_code,
    output logic [CODE_W-1:0]  o_q_code,
    output logic               o_short_press,
    output logic               o_mode_toggled,
    output logic               o_rx_mode,
    output logic [MOD_W-1:0]   o_mod_select
);

    // control state
    logic [CFG_W-1:0]     r_debounce, r_long;
    logic [MOD_W-1:0]     r_mod;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_stable, r_cand, r_long_done, r_rx;
    logic [TIME_BITS-1:0] r_change, r_press;
    logic                 r_out_valid;
    logic                 r_short, r_toggle, r_sym_act;
    // payload
    logic                 r_level;
    logic [TIME_BITS-1:0] r_now;
    logic [PROD_W-1:0]    r_quo_i, r_quo_q;
    logic [IDX_W-1:0]     r_rem_i, r_rem_q, r_div;

    // symbol set-up
    logic [MOD_W-1:0]     bits;
    logic [IDX_W-1:0]     mask, idx_i, idx_q;
    logic [CNT_W:0]       order, cnt_inc;
    logic [CNT_W-1:0]     n_cnt;
    logic [MOD_W-1:0]     n_mod;

    always_comb begin
        bits    = r_mod + MOD_W'(1);
        mask    = IDX_W'(((IDX_W + 1)'(1) << bits) - (IDX_W + 1)'(1));
        idx_i   = r_cnt[IDX_W-1:0] & mask;
        idx_q   = IDX_W'(r_cnt >> bits);
        // 4^b: shift by twice the bits per axis
        order   = (CNT_W + 1)'(1) << {bits, 1'b0};
        cnt_inc = {1'b0, r_cnt} + (CNT_W + 1)'(1);
        n_cnt   = (cnt_inc >= order) ? '0 : cnt_inc[CNT_W-1:0];
        n_mod   = (r_mod == MOD_W'(NUM_MODS - 1)) ? '0 : r_mod + MOD_W'(1);
    end

    // restoring divide step, one quotient bit per lane
    logic [IDX_W:0] sh_i, sh_q;
    logic           ge_i, ge_q;

    always_comb begin
        sh_i = {r_rem_i, r_quo_i[PROD_W-1]};
        sh_q = {r_rem_q, r_quo_q[PROD_W-1]};
        ge_i = sh_i >= {1'b0, r_div};
        ge_q = sh_q >= {1'b0, r_div};
    end

    // button evaluation
    logic                 lvl_chg, cand_n, deb_ok;
    logic [TIME_BITS-1:0] since_chg, held, held_l;

    always_comb begin
        lvl_chg   = (r_level != r_cand);
        cand_n    = r_level;
        since_chg = r_now - r_change;
        held      = r_now - r_press;
        held_l    = r_now - r_press;
        deb_ok    = (cand_n != r_stable) &&
                    (lvl_chg ? (r_debounce == '0)
                             : (since_chg >= TIME_BITS'(r_debounce)));
    end

    assign o_stat.in_op    = i_op;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= DEBOUNCE_RST;
            r_long      <= LONG_RST;
            r_mod       <= '0;
            r_cnt       <= '0;
            r_stable    <= 1'b1;
            r_cand      <= 1'b1;
            r_change    <= '0;
            r_press     <= '0;
            r_long_done <= 1'b0;
            r_rx        <= 1'b0;
            r_out_valid <= 1'b0;
            r_short     <= 1'b0;
            r_toggle    <= 1'b0;
            r_sym_act   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_DEBOUNCE: r_debounce <= i_cfg_data;
                    REG_LONG:     r_long     <= i_cfg_data;
                    default:      ;
                endcase
            end

            if (i_cmd.take_in) begin
                r_short   <= 1'b0;
                r_toggle  <= 1'b0;
                r_sym_act <= (i_op == OP_SYMBOL) && !r_rx;
                if (i_op == OP_SYMBOL && !r_rx) begin
                    r_cnt <= n_cnt;
                end
            end

            if (i_cmd.poll_deb) begin
                if (lvl_chg) begin
                    r_cand   <= cand_n;
                    r_change <= r_now;
                end
                if (deb_ok) begin
                    r_stable <= cand_n;
                    if (!cand_n) begin
                        r_press     <= r_now;
                        r_long_done <= 1'b0;
                    end else if (!r_long_done && held < TIME_BITS'(r_long) && !r_rx) begin
                        r_mod   <= n_mod;
                        r_cnt   <= '0;
                        r_short <= 1'b1;
                    end
                end
            end

            if (i_cmd.poll_long) begin
                if (!r_stable && !r_long_done && held_l >= TIME_BITS'(r_long)) begin
                    r_long_done <= 1'b1;
                    r_rx        <= !r_rx;
                    r_cnt       <= '0;
                    r_toggle    <= 1'b1;
                end
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_level <= i_button_level;
            r_now   <= i_now_ms[TIME_BITS-1:0];
            r_quo_i <= PROD_W'(idx_i) * PROD_W'(DAC_FULL_SCALE);
            r_quo_q <= PROD_W'(idx_q) * PROD_W'(DAC_FULL_SCALE);
            r_rem_i <= '0;
            r_rem_q <= '0;
            r_div   <= mask;
        end else if (i_cmd.div_step) begin
            r_rem_i <= ge_i ? IDX_W'(sh_i - {1'b0, r_div}) : sh_i[IDX_W-1:0];
            r_rem_q <= ge_q ? IDX_W'(sh_q - {1'b0, r_div}) : sh_q[IDX_W-1:0];
            r_quo_i <= {r_quo_i[PROD_W-2:0], ge_i};
            r_quo_q <= {r_quo_q[PROD_W-2:0], ge_q};
        end

        if (i_cmd.load_out) begin
            o_dac_valid    <= r_sym_act;
            o_i_code       <= r_sym_act ? r_quo_i[CODE_W-1:0] : '0;
            o_q_code       <= r_sym_act ? r_quo_q[CODE_W-1:0] : '0;
            o_short_press  <= r_short;
            o_mode_toggled <= r_toggle;
            o_rx_mode      <= r_rx;
            o_mod_select   <= r_mod;
        end
    end

    // sweep counter never reaches the constellation order
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt >> {bits, 1'b0}) == '0)
        else $error("symbol counter beyond constellation order");

    // modulation select stays among the supported orders
    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mod < MOD_W'(NUM_MODS))
        else $error("modulation select out of range");

    // a release advance and a held-press toggle cannot share one poll
    a_press_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_short && r_toggle))
        else $error("short press and mode toggle on the same poll");

    // symbol codes only come out in transmit mode and never with button events
    a_dac_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out && r_sym_act |=> !o_rx_mode && !o_short_press && !o_mode_toggled)
        else $error("DAC codes with receive mode or button event");

endmodule

// File: dv/qam_sweep_with_button_control_unit_test.sv
// Self-checking testbench for qam_sweep_with_button_control_unit: a directed table and then
// random press episodes and symbol edges, each result checked against an in-bench predictor.
// Depends on qamsw_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module qam_sweep_with_button_control_unit_test;
    import qamsw_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 4;
    localparam int QUIET_LIMIT   = 4000;  // cycles with no transfer at all before giving up
    localparam int SETTLE_CYCLES = 30;    // idle wait after the last result before the next phase
    localparam int DIRECTED_ROWS = 26;
    localparam int RANDOM_ITEMS  = 1025;
    localparam int TOTAL_ITEMS   = DIRECTED_ROWS + RANDOM_ITEMS;
    localparam int NUM_SETTINGS  = 5;

    localparam logic LVL_PRESSED  = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;

    // index with no register behind it, writes must be ignored
    localparam logic [CIDX_W-1:0] REG_SPARE = CIDX_W'(2);

    typedef struct packed {
        logic              dac_valid;
        logic [CODE_W-1:0] i_code;
        logic [CODE_W-1:0] q_code;
        logic              short_press;
        logic              mode_toggled;
        logic              rx_mode;
        logic [MOD_W-1:0]  mod_select;
    } t_sweep_result;

    typedef struct {
        logic          op;
        logic          level;
        logic [31:0]   now;
        logic          typed;   // want holds a hand-worked answer
        t_sweep_result want;
    } t_stim_row;

    // ---------------------------------------------------------------- DUT ports
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic               i_op           = 1'b0;
    logic               i_button_level = 1'b1;
    logic [31:0]        i_now_ms       = '0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic               o_dac_valid;
    logic [CODE_W-1:0]  o_i_code;
    logic [CODE_W-1:0]  o_q_code;
    logic               o_short_press;
    logic               o_mode_toggled;
    logic               o_rx_mode;
    logic [MOD_W-1:0]   o_mod_select;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [CIDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_W-1:0]   i_cfg_data     = '0;

    qam_sweep_with_button_control_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_button_level (i_button_level),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_dac_valid    (o_dac_valid),
        .o_i_code       (o_i_code),
        .o_q_code       (o_q_code),
        .o_short_press  (o_short_press),
        .o_mode_toggled (o_mode_toggled),
        .o_rx_mode      (o_rx_mode),
        .o_mod_select   (o_mod_select),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ---------------------------------------------------------------- bench state
    t_sweep_result awaited_results[$];   // one entry per accepted item, oldest first
    t_sweep_result oldest_result;
    int            mismatches    = 0;
    int            items_sent    = 0;
    int            send_idle_pct = 27;
    int            recv_idle_pct = 73;
    int            quiet_cycles  = 0;
    logic [31:0]   t_ms;                 // running millisecond time for the button model

    t_stim_row     plan[DIRECTED_ROWS];
    logic [15:0]   settings_deb[NUM_SETTINGS]  = '{16'd7, 16'd0, 16'd65535, 16'd1, 16'd50};
    logic [15:0]   settings_long[NUM_SETTINGS] = '{16'd40, 16'd0, 16'd65535, 16'd1, 16'd1500};

    // ---------------------------------------------------------------- predictor
    // Mirror of the unit's registers and state; updated once per accepted transfer.
    logic [15:0]       deb_ms, long_ms;
    logic [MOD_W-1:0]  mod_sel;
    logic [CNT_W-1:0]  sym_count;
    logic              stable_lvl, cand_lvl, long_seen, rx_on;
    logic [31:0]       change_at, press_at;

    task automatic restore_defaults();
        deb_ms     = DEBOUNCE_RST;
        long_ms    = LONG_RST;
        mod_sel    = '0;
        sym_count  = '0;
        stable_lvl = LVL_RELEASED;
        cand_lvl   = LVL_RELEASED;
        change_at  = '0;
        press_at   = '0;
        long_seen  = 1'b0;
        rx_on      = 1'b0;
    endtask

    // index * full scale / (levels - 1), truncated; bits is never below one
    function automatic logic [CODE_W-1:0] axis_code(int unsigned idx, int unsigned bits);
        int unsigned top;
        top = (1 << bits) - 1;
        return CODE_W'((idx * DAC_FULL_SCALE) / top);
    endfunction

    task automatic predict_sweep(input logic op, input logic level, input logic [31:0] now,
                                 output t_sweep_result res);
        int unsigned bits, levels;
        res = '0;
        if (op == OP_SYMBOL) begin
            // ignored altogether in receive mode
            if (!rx_on) begin
                bits          = mod_sel + 1;
                levels        = 1 << bits;
                res.dac_valid = 1'b1;
                res.i_code    = axis_code(sym_count & (levels - 1), bits);
                res.q_code    = axis_code(sym_count >> bits, bits);
                if (sym_count + 1 >= levels * levels)
                    sym_count = '0;
                else
                    sym_count = sym_count + 1'b1;
            end
        end else begin
            if (level != cand_lvl) begin
                cand_lvl  = level;
                change_at = now;
            end
            // time differences wrap with the 32-bit millisecond count
            if (cand_lvl != stable_lvl && (now - change_at) >= deb_ms) begin
                stable_lvl = cand_lvl;
                if (stable_lvl == LVL_PRESSED) begin
                    press_at  = now;
                    long_seen = 1'b0;
                end else if (!long_seen && (now - press_at) < long_ms && !rx_on) begin
                    mod_sel         = (mod_sel == NUM_MODS - 1) ? '0 : mod_sel + 1'b1;
                    sym_count       = '0;
                    res.short_press = 1'b1;
                end
            end
            // with long_ms at zero this fires on the very poll that accepts the press
            if (stable_lvl == LVL_PRESSED && !long_seen && (now - press_at) >= long_ms) begin
                long_seen        = 1'b1;
                rx_on            = !rx_on;
                sym_count        = '0;
                res.mode_toggled = 1'b1;
            end
        end
        res.rx_mode    = rx_on;
        res.mod_select = mod_sel;
    endtask

    // ---------------------------------------------------------------- directed table helpers
    function automatic t_sweep_result outcome(logic dv, int unsigned ic, int unsigned qc,
                                              logic sp, logic mt, logic rx, int unsigned ms);
        t_sweep_result r;
        r.dac_valid    = dv;
        r.i_code       = CODE_W'(ic);
        r.q_code       = CODE_W'(qc);
        r.short_press  = sp;
        r.mode_toggled = mt;
        r.rx_mode      = rx;
        r.mod_select   = MOD_W'(ms);
        return r;
    endfunction

    function automatic t_stim_row step_row(logic op, logic level, logic [31:0] now);
        t_stim_row r;
        r.op    = op;
        r.level = level;
        r.now   = now;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_stim_row sure_row(logic op, logic level, logic [31:0] now,
                                           t_sweep_result want);
        t_stim_row r;
        r       = step_row(op, level, now);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // ---------------------------------------------------------------- input side
    // One item per call. The idling split follows progress through the run: sender light
    // and sink heavy first, then the reverse, then a stretch with no idling at all.
    task automatic send_item(input logic op, input logic level, input logic [31:0] now,
                             input logic typed, input t_sweep_result want);
        t_sweep_result res;
        if (items_sent < TOTAL_ITEMS / 3) begin
            send_idle_pct = 27;
            recv_idle_pct = 73;
        end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
            send_idle_pct = 73;
            recv_idle_pct = 27;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_button_level <= level;
        i_now_ms       <= now;
        // payload held until the transfer happens
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_sweep(op, level, now, res);
        awaited_results.push_back(typed ? want : res);
        items_sent++;
    endtask

    // level and time are don't-care on a symbol edge, so they get random content
    task automatic send_symbol();
        send_item(OP_SYMBOL, 1'($urandom_range(0, 1)), $urandom, 1'b0, '0);
    endtask

    // a poll at the current time, sometimes followed by a few symbol edges
    task automatic send_poll(input logic level);
        send_item(OP_POLL, level, t_ms, 1'b0, '0);
        if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 3)) send_symbol();
    endtask

    // Press and release with plausible timing around the current thresholds:
    // optional contact bounce, debounced press, short or long hold, debounced release.
    task automatic press_episode();
        logic        want_long;
        int unsigned hold;
        want_long = ($urandom_range(0, 99) < 35);
        if ($urandom_range(0, 99) < 25) begin
            send_poll(LVL_PRESSED);
            t_ms += (deb_ms > 0) ? $urandom_range(0, deb_ms - 1) : 0;
            send_poll(LVL_RELEASED);
        end
        send_poll(LVL_PRESSED);
        t_ms += deb_ms + $urandom_range(0, 2);
        send_poll(LVL_PRESSED);
        // a short hold has to leave room for the release debounce
        if (want_long)
            hold = long_ms + $urandom_range(0, 3);
        else if (int'(long_ms) > int'(deb_ms) + 3)
            hold = $urandom_range(0, int'(long_ms) - int'(deb_ms) - 3);
        else
            hold = $urandom_range(0, 3);
        if (hold > 1 && $urandom_range(0, 1)) begin
            t_ms += hold / 2;
            send_poll(LVL_PRESSED);
            t_ms += hold - hold / 2;
        end else begin
            t_ms += hold;
        end
        send_poll(LVL_PRESSED);
        send_poll(LVL_RELEASED);
        t_ms += deb_ms + $urandom_range(0, 2);
        send_poll(LVL_RELEASED);
        t_ms += $urandom_range(0, 50);
    endtask

    // sender holds off until every result is back, then lets the unit settle
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only ever called with the unit idle
    task automatic load_settings(input logic [15:0] deb, input logic [15:0] lng,
                                 input logic poke_spare);
        logic [CIDX_W-1:0] idx[3];
        logic [CFG_W-1:0]  val[3];
        idx = '{REG_SPARE, REG_DEBOUNCE, REG_LONG};
        val = '{CFG_W'($urandom), deb, lng};
        for (int k = poke_spare ? 0 : 1; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            if (idx[k] == REG_DEBOUNCE)
                deb_ms = val[k];
            else if (idx[k] == REG_LONG)
                long_ms = val[k];
        end
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- result side
    task automatic check_field(input string label, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s expected %0d got %0d", $time, label, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected", $time);
                    mismatches++;
                end else begin
                    oldest_result = awaited_results.pop_front();
                    check_field("dac_valid", oldest_result.dac_valid, o_dac_valid);
                    check_field("i_code", oldest_result.i_code, o_i_code);
                    check_field("q_code", oldest_result.q_code, o_q_code);
                    check_field("short_press", oldest_result.short_press, o_short_press);
                    check_field("mode_toggled", oldest_result.mode_toggled, o_mode_toggled);
                    check_field("rx_mode", oldest_result.rx_mode, o_rx_mode);
                    check_field("mod_select", oldest_result.mod_select, o_mod_select);
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("qam_sweep_with_button_control_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial begin
        int unsigned pick;
        int          phase_end;
        restore_defaults();

        // Directed part, reset settings (debounce 50, long press 1500).
        // QPSK sweep: the four corners in counter order, then the wrap to zero.
        plan[0]  = sure_row(OP_SYMBOL, 1'b0, 32'd0,  outcome(1, 0, 0, 0, 0, 0, 0));
        plan[1]  = sure_row(OP_SYMBOL, 1'b1, 32'd0,  outcome(1, 4095, 0, 0, 0, 0, 0));
        plan[2]  = sure_row(OP_SYMBOL, 1'b0, 32'd0,  outcome(1, 0, 4095, 0, 0, 0, 0));
        plan[3]  = sure_row(OP_SYMBOL, 1'b1, 32'd0,  outcome(1, 4095, 4095, 0, 0, 0, 0));
        plan[4]  = sure_row(OP_SYMBOL, 1'b0, 32'd0,  outcome(1, 0, 0, 0, 0, 0, 0));
        // poll with the button at rest: codes stay at zero
        plan[5]  = sure_row(OP_POLL, LVL_RELEASED, 32'd0, outcome(0, 0, 0, 0, 0, 0, 0));
        // short press in transmit mode advances to 16-QAM and clears the counter
        plan[6]  = step_row(OP_POLL, LVL_PRESSED,  32'd100);
        plan[7]  = step_row(OP_POLL, LVL_PRESSED,  32'd150);
        plan[8]  = step_row(OP_POLL, LVL_RELEASED, 32'd200);
        plan[9]  = sure_row(OP_POLL, LVL_RELEASED, 32'd250, outcome(0, 0, 0, 1, 0, 0, 1));
        plan[10] = sure_row(OP_SYMBOL, 1'b0, 32'd0, outcome(1, 0, 0, 0, 0, 0, 1));
        // long press toggles to receive; symbol edges then do nothing
        plan[11] = step_row(OP_POLL, LVL_PRESSED,  32'd1000);
        plan[12] = step_row(OP_POLL, LVL_PRESSED,  32'd1050);
        plan[13] = sure_row(OP_POLL, LVL_PRESSED,  32'd2550, outcome(0, 0, 0, 0, 1, 1, 1));
        plan[14] = sure_row(OP_SYMBOL, 1'b1, 32'd0, outcome(0, 0, 0, 0, 0, 1, 1));
        // release after the long press must not advance
        plan[15] = step_row(OP_POLL, LVL_RELEASED, 32'd2600);
        plan[16] = step_row(OP_POLL, LVL_RELEASED, 32'd2650);
        // short press while receiving: no advance either
        plan[17] = step_row(OP_POLL, LVL_PRESSED,  32'd3000);
        plan[18] = step_row(OP_POLL, LVL_PRESSED,  32'd3050);
        plan[19] = step_row(OP_POLL, LVL_RELEASED, 32'd3100);
        plan[20] = step_row(OP_POLL, LVL_RELEASED, 32'd3150);
        // press debounced across the 32-bit wrap of the millisecond time
        plan[21] = step_row(OP_POLL, LVL_PRESSED,  32'hFFFF_FFF0);
        plan[22] = step_row(OP_POLL, LVL_PRESSED,  32'h0000_0022);
        plan[23] = step_row(OP_POLL, LVL_RELEASED, 32'h0000_0030);
        plan[24] = step_row(OP_POLL, LVL_RELEASED, 32'h0000_0062);
        plan[25] = step_row(OP_SYMBOL, 1'b1, 32'hFFFF_FFFF);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIRECTED_ROWS; k++)
            send_item(plan[k].op, plan[k].level, plan[k].now, plan[k].typed, plan[k].want);

        // Random part, one phase per register setting, extremes included.
        t_ms = $urandom;
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            wait_quiet();
            load_settings(settings_deb[p], settings_long[p], p == 0 || p == 3);
            phase_end = DIRECTED_ROWS + (p + 1) * RANDOM_ITEMS / NUM_SETTINGS;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    send_symbol();
                end else if (pick < 85) begin
                    press_episode();
                end else begin
                    // stray poll, now and then at an arbitrary point in time
                    if ($urandom_range(0, 3) == 0)
                        t_ms = $urandom;
                    else
                        t_ms += $urandom_range(0, 2 * int'(deb_ms) + 2);
                    send_poll(1'($urandom_range(0, 1)));
                end
            end
        end

        wait_quiet();
        if (mismatches == 0)
            $display("qam_sweep_with_button_control_unit verification clean");
        else
            $display("qam_sweep_with_button_control_unit verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/qamsw_pkg.sv
rtl/core/qamsw_ctrl.sv
rtl/core/qamsw_dp.sv
rtl/core/qam_sweep_with_button_control_unit.sv
dv/qam_sweep_with_button_control_unit_test.sv
